// ===== rtl/mes_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mes_pkg;

    // fixed datapath widths
    localparam int GRAD_W = 36;
    localparam int DEC_W  = 48;
    localparam int PT_W   = 14;

    // configuration reset values
    localparam int RADIUS_X_RESET = 100;
    localparam int RADIUS_Y_RESET = 50;
    localparam int CENTER_X_RESET = 200;
    localparam int CENTER_Y_RESET = 200;

    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_RADIUS_X = 2'd0;
    localparam t_cfg_index CFG_RADIUS_Y = 2'd1;
    localparam t_cfg_index CFG_CENTER_X = 2'd2;
    localparam t_cfg_index CFG_CENTER_Y = 2'd3;

    // multiplier op counter: last op of each sequence
    typedef logic [2:0] t_op;
    localparam t_op OP_FIRST     = 3'd0;
    localparam t_op OP_INIT_LAST = 3'd2;
    localparam t_op OP_R2_LAST   = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_EMIT,
        ST_R2
    } t_state;

    typedef struct packed {
        logic done;
        logic go_region_two;
    } t_step_flags;

endpackage

`default_nettype wire

// ===== rtl/mes_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mes_step
    import mes_pkg::*;
#(
    parameter int RADIUS_BITS = 10
) (
    input  wire logic [RADIUS_BITS-1:0]   i_cur_x,
    input  wire logic [RADIUS_BITS-1:0]   i_cur_y,
    input  wire logic [GRAD_W-1:0]        i_grad_x,
    input  wire logic [GRAD_W-1:0]        i_grad_y,
    input  wire logic [DEC_W-1:0]         i_decision,
    input  wire logic [2*RADIUS_BITS-1:0] i_rx_sq,
    input  wire logic [2*RADIUS_BITS-1:0] i_ry_sq,
    input  wire logic                     i_region_two,
    output logic      [RADIUS_BITS-1:0]   o_cur_x,
    output logic      [RADIUS_BITS-1:0]   o_cur_y,
    output logic      [GRAD_W-1:0]        o_grad_x,
    output logic      [GRAD_W-1:0]        o_grad_y,
    output logic      [DEC_W-1:0]         o_decision,
    output t_step_flags                   o_flags
);

    logic [GRAD_W-1:0]      gx_inc;
    logic [GRAD_W-1:0]      gy_dec;
    logic [DEC_W-1:0]       gx4;
    logic [DEC_W-1:0]       gy4;
    logic [DEC_W-1:0]       rx4;
    logic [DEC_W-1:0]       ry4;
    logic [RADIUS_BITS-1:0] x_inc;
    logic [RADIUS_BITS-1:0] y_dec;
    logic                   dec_neg;
    logic                   dec_pos;

    always_comb begin
        gx_inc  = i_grad_x + GRAD_W'({i_ry_sq, 1'b0});
        gy_dec  = i_grad_y - GRAD_W'({i_rx_sq, 1'b0});
        gx4     = DEC_W'({gx_inc, 2'b00});
        gy4     = DEC_W'({gy_dec, 2'b00});
        rx4     = DEC_W'({i_rx_sq, 2'b00});
        ry4     = DEC_W'({i_ry_sq, 2'b00});
        x_inc   = i_cur_x + RADIUS_BITS'(1);
        y_dec   = i_cur_y - RADIUS_BITS'(1);
        dec_neg = i_decision[DEC_W-1];
        dec_pos = !dec_neg && (i_decision != '0);

        o_cur_x    = i_cur_x;
        o_cur_y    = i_cur_y;
        o_grad_x   = i_grad_x;
        o_grad_y   = i_grad_y;
        o_decision = i_decision;
        o_flags.done          = (i_cur_y == '0);
        o_flags.go_region_two = 1'b0;

        if (!i_region_two) begin
            // region 1: x always advances
            o_cur_x  = x_inc;
            o_grad_x = gx_inc;
            if (dec_neg) begin
                o_decision = i_decision + gx4 + ry4;
            end else begin
                o_cur_y    = y_dec;
                o_grad_y   = gy_dec;
                o_decision = i_decision + gx4 - gy4 + ry4;
            end
            o_flags.go_region_two = !($signed(o_grad_x) < $signed(o_grad_y));
        end else begin
            // region 2: y always drops
            o_cur_y  = y_dec;
            o_grad_y = gy_dec;
            if (dec_pos) begin
                o_decision = i_decision + rx4 - gy4;
            end else begin
                o_cur_x    = x_inc;
                o_grad_x   = gx_inc;
                o_decision = i_decision + gx4 - gy4 + rx4;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/midpoint_ellipse_stepper_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Midpoint ellipse stepper.
// Input channel (i_in_valid / o_in_ready) carries one word, i_restart.
// restart = 1 starts a new ellipse at (0, radius_y); restart = 0 advances
// one step. Every input word yields exactly one output word on
// o_out_valid / i_out_ready: the four symmetric pixels, points_valid and
// done_res (set on the y = 0 point). A step word after done, or before any
// restart, returns an all-zero word.
// Config: i_cfg_we / i_cfg_index / i_cfg_data; the user must write them only
// while idle, as the block does not enforce it. Radii are squared at
// restart; center is read at every step. The output word is registered. A
// restart first computes three products on the shared multiplier. The step
// that enters region 2 then computes five dependent products before the
// next word is taken. With the shared multiplier and the one-word-at-a-time
// sequencer, a new word is taken only once the last has been emitted;
// o_in_ready is high only in the idle state.
// The output register holds a finished word while the receiver stalls; a
// new word is accepted meanwhile, but its result waits for the slot.
// Reset (synchronous, active low) loads the default radii and center and
// leaves the walk finished, so steps return zero until a restart.

module midpoint_ellipse_stepper_top
    import mes_pkg::*;
#(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 12
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [1:0]                             i_cfg_index,
    input  wire logic [((RADIUS_BITS > COORD_BITS) ? RADIUS_BITS : COORD_BITS)-1:0] i_cfg_data,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic                                   i_restart,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic signed [PT_W-1:0]                      o_pt_a_x,
    output logic signed [PT_W-1:0]                      o_pt_a_y,
    output logic signed [PT_W-1:0]                      o_pt_b_x,
    output logic signed [PT_W-1:0]                      o_pt_b_y,
    output logic signed [PT_W-1:0]                      o_pt_c_x,
    output logic signed [PT_W-1:0]                      o_pt_c_y,
    output logic signed [PT_W-1:0]                      o_pt_d_x,
    output logic signed [PT_W-1:0]                      o_pt_d_y,
    output logic                                        o_points_valid,
    output logic                                        o_done_res
);

    localparam int RB = RADIUS_BITS;
    localparam int CB = COORD_BITS;
    localparam int SQ = 2 * RADIUS_BITS;
    // operand width: (2x+1)^2 is the widest operand
    localparam int MW = 2 * RADIUS_BITS + 2;

    // configuration
    logic [RB-1:0] r_radius_x;
    logic [RB-1:0] r_radius_y;
    logic [CB-1:0] r_center_x;
    logic [CB-1:0] r_center_y;

    // walk state
    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [RB-1:0]     r_cur_x, n_cur_x;
    logic [RB-1:0]     r_cur_y, n_cur_y;
    logic [GRAD_W-1:0] r_grad_x, n_grad_x;
    logic [GRAD_W-1:0] r_grad_y, n_grad_y;
    logic [DEC_W-1:0]  r_decision, n_decision;
    logic [SQ-1:0]     r_rx_sq, n_rx_sq;
    logic [SQ-1:0]     r_ry_sq, n_ry_sq;
    logic [MW-1:0]     r_tmp, n_tmp;
    logic              r_region_two, n_region_two;
    logic              r_finished, n_finished;

    // output word
    logic              r_out_valid, n_out_valid;
    logic [PT_W-1:0]   r_sum_x, n_sum_x;
    logic [PT_W-1:0]   r_dif_x, n_dif_x;
    logic [PT_W-1:0]   r_sum_y, n_sum_y;
    logic [PT_W-1:0]   r_dif_y, n_dif_y;
    logic              r_pts_valid, n_pts_valid;
    logic              r_done, n_done;

    // shared multiplier
    logic [MW-1:0]     mul_a;
    logic [MW-1:0]     mul_b;
    logic [2*MW-1:0]   prod;
    logic [DEC_W-1:0]  prod_d;

    // step datapath
    logic [RB-1:0]     s_cur_x;
    logic [RB-1:0]     s_cur_y;
    logic [GRAD_W-1:0] s_grad_x;
    logic [GRAD_W-1:0] s_grad_y;
    logic [DEC_W-1:0]  s_decision;
    t_step_flags       s_flags;

    logic [PT_W-1:0]   cx_p, cy_p, x_p, y_p;
    logic [RB-1:0]     ym;
    logic              slot_free;

    mes_step #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_step (
        .i_cur_x      (r_cur_x),
        .i_cur_y      (r_cur_y),
        .i_grad_x     (r_grad_x),
        .i_grad_y     (r_grad_y),
        .i_decision   (r_decision),
        .i_rx_sq      (r_rx_sq),
        .i_ry_sq      (r_ry_sq),
        .i_region_two (r_region_two),
        .o_cur_x      (s_cur_x),
        .o_cur_y      (s_cur_y),
        .o_grad_x     (s_grad_x),
        .o_grad_y     (s_grad_y),
        .o_decision   (s_decision),
        .o_flags      (s_flags)
    );

    assign prod   = mul_a * mul_b;
    assign prod_d = DEC_W'(prod);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_x <= RB'(RADIUS_X_RESET);
            r_radius_y <= RB'(RADIUS_Y_RESET);
            r_center_x <= CB'(CENTER_X_RESET);
            r_center_y <= CB'(CENTER_Y_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RADIUS_X: r_radius_x <= RB'(i_cfg_data);
                CFG_RADIUS_Y: r_radius_y <= RB'(i_cfg_data);
                CFG_CENTER_X: r_center_x <= CB'(i_cfg_data);
                CFG_CENTER_Y: r_center_y <= CB'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_op         <= OP_FIRST;
            r_region_two <= 1'b0;
            r_finished   <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_op         <= n_op;
            r_region_two <= n_region_two;
            r_finished   <= n_finished;
            r_out_valid  <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cur_x     <= n_cur_x;
        r_cur_y     <= n_cur_y;
        r_grad_x    <= n_grad_x;
        r_grad_y    <= n_grad_y;
        r_decision  <= n_decision;
        r_rx_sq     <= n_rx_sq;
        r_ry_sq     <= n_ry_sq;
        r_tmp       <= n_tmp;
        r_sum_x     <= n_sum_x;
        r_dif_x     <= n_dif_x;
        r_sum_y     <= n_sum_y;
        r_dif_y     <= n_dif_y;
        r_pts_valid <= n_pts_valid;
        r_done      <= n_done;
    end

    always_comb begin
        cx_p = PT_W'(r_center_x);
        cy_p = PT_W'(r_center_y);
        x_p  = PT_W'(r_cur_x);
        y_p  = PT_W'(r_cur_y);
        // (y-1)^2 with y = 0 wrapping to -1
        ym   = (r_cur_y == '0) ? RB'(1) : (r_cur_y - RB'(1));
        slot_free = !r_out_valid || i_out_ready;

        n_state      = r_state;
        n_op         = r_op;
        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_grad_x     = r_grad_x;
        n_grad_y     = r_grad_y;
        n_decision   = r_decision;
        n_rx_sq      = r_rx_sq;
        n_ry_sq      = r_ry_sq;
        n_tmp        = r_tmp;
        n_region_two = r_region_two;
        n_finished   = r_finished;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_sum_x      = r_sum_x;
        n_dif_x      = r_dif_x;
        n_sum_y      = r_sum_y;
        n_dif_y      = r_dif_y;
        n_pts_valid  = r_pts_valid;
        n_done       = r_done;
        mul_a        = '0;
        mul_b        = '0;
        o_in_ready   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                n_op       = OP_FIRST;
                if (i_in_valid) begin
                    n_state = i_restart ? ST_INIT : ST_EMIT;
                end
            end

            ST_INIT: begin
                n_op = r_op + t_op'(1);
                unique case (r_op)
                    3'd0: begin
                        mul_a   = MW'(r_radius_x);
                        mul_b   = MW'(r_radius_x);
                        n_rx_sq = SQ'(prod);
                    end
                    3'd1: begin
                        mul_a   = MW'(r_radius_y);
                        mul_b   = MW'(r_radius_y);
                        n_ry_sq = SQ'(prod);
                    end
                    default: begin
                        // rx^2 * ry feeds both grad_y and the region 1 start
                        mul_a        = MW'(r_rx_sq);
                        mul_b        = MW'(r_radius_y);
                        n_cur_x      = '0;
                        n_cur_y      = r_radius_y;
                        n_grad_x     = '0;
                        n_grad_y     = GRAD_W'({prod_d, 1'b0});
                        n_decision   = DEC_W'({r_ry_sq, 2'b00})
                                     - DEC_W'({prod_d, 2'b00})
                                     + DEC_W'(r_rx_sq);
                        n_region_two = 1'b0;
                        n_finished   = 1'b0;
                    end
                endcase
                if (r_op == OP_INIT_LAST) begin
                    n_state = ST_EMIT;
                end
            end

            ST_EMIT: begin
                // region 2 seeding counts its products from zero
                n_op = OP_FIRST;
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    if (r_finished) begin
                        n_sum_x     = '0;
                        n_dif_x     = '0;
                        n_sum_y     = '0;
                        n_dif_y     = '0;
                        n_pts_valid = 1'b0;
                        n_done      = 1'b0;
                    end else begin
                        n_sum_x     = cx_p + x_p;
                        n_dif_x     = cx_p - x_p;
                        n_sum_y     = cy_p + y_p;
                        n_dif_y     = cy_p - y_p;
                        n_pts_valid = 1'b1;
                        n_done      = s_flags.done;
                        if (s_flags.done) begin
                            n_finished = 1'b1;
                        end else begin
                            n_cur_x    = s_cur_x;
                            n_cur_y    = s_cur_y;
                            n_grad_x   = s_grad_x;
                            n_grad_y   = s_grad_y;
                            n_decision = s_decision;
                            if (s_flags.go_region_two) begin
                                n_region_two = 1'b1;
                                n_state      = ST_R2;
                            end
                        end
                    end
                end
            end

            ST_R2: begin
                // decision = ry^2 (2x+1)^2 + 4 rx^2 (y-1)^2 - 4 rx^2 ry^2
                n_op = r_op + t_op'(1);
                unique case (r_op)
                    3'd0: begin
                        mul_a = MW'({r_cur_x, 1'b1});
                        mul_b = MW'({r_cur_x, 1'b1});
                        n_tmp = MW'(prod);
                    end
                    3'd1: begin
                        mul_a      = MW'(r_ry_sq);
                        mul_b      = r_tmp;
                        n_decision = prod_d;
                    end
                    3'd2: begin
                        mul_a = MW'(ym);
                        mul_b = MW'(ym);
                        n_tmp = MW'(prod);
                    end
                    3'd3: begin
                        mul_a      = MW'(r_rx_sq);
                        mul_b      = r_tmp;
                        n_decision = r_decision + DEC_W'({prod_d, 2'b00});
                    end
                    default: begin
                        mul_a      = MW'(r_rx_sq);
                        mul_b      = MW'(r_ry_sq);
                        n_decision = r_decision - DEC_W'({prod_d, 2'b00});
                    end
                endcase
                if (r_op == OP_R2_LAST) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_pt_a_x       = r_sum_x;
    assign o_pt_a_y       = r_sum_y;
    assign o_pt_b_x       = r_dif_x;
    assign o_pt_b_y       = r_dif_y;
    assign o_pt_c_x       = r_sum_x;
    assign o_pt_c_y       = r_dif_y;
    assign o_pt_d_x       = r_dif_x;
    assign o_pt_d_y       = r_sum_y;
    assign o_points_valid = r_pts_valid;
    assign o_done_res     = r_done;

endmodule

`default_nettype wire
